### src/shacal2_block_cipher_assert.svh
// Assertion macros used by the SHACAL-2 core module.
`ifndef SHACAL2_BLOCK_CIPHER_ASSERT_SVH
`define SHACAL2_BLOCK_CIPHER_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define SHC2_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define SHC2_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/shc2_pkg.sv
// Types, codes and round functions for the SHACAL-2 core.
`default_nettype none
package shc2_pkg;

    localparam int KEY_SLOTS = 64;
    localparam int KEY_AW    = $clog2(KEY_SLOTS);

    typedef logic [31:0]      word_t;
    typedef word_t [7:0]      blk_t;    // index 0 is word a
    typedef logic [KEY_AW-1:0] kidx_t;

    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_ENC  = 2'd1,
        OP_DEC  = 2'd2
    } op_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_RUN  = 1'b1
    } state_t;

    function automatic word_t big_s0(input word_t x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic word_t big_s1(input word_t x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic word_t ch32(input word_t e, input word_t f, input word_t g);
        return (e & f) ^ (~e & g);
    endfunction

    function automatic word_t maj32(input word_t a, input word_t b, input word_t c);
        return (a & b) ^ (a & c) ^ (b & c);
    endfunction

endpackage
`default_nettype wire

### src/shacal2_block_cipher.sv
// SHACAL-2 core: a single round unit runs ROUNDS rounds per block, one round per
// cycle with one key-store read per round; the last round waits while the result
// register is full. A block is taken only once the last block's rounds are done.
// The result register lets the next block run while a result waits.
// Reset clears control only; key store contents are undefined until loaded.
`default_nettype none
`include "shacal2_block_cipher_assert.svh"
module shacal2_block_cipher #(
    parameter int ROUNDS = 64
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // key_index[5:0], key_word[37:6], word_a[69:38] .. word_h[293:262], zero pad
    input  wire logic [295:0] s_tdata,
    // operation[1:0]
    input  wire logic [1:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // out_a[31:0], out_b[63:32] .. out_h[255:224]
    output logic      [255:0] m_tdata
);
    import shc2_pkg::*;

    localparam kidx_t LAST_IDX = kidx_t'(ROUNDS - 1);

    state_t state_reg, state_next;
    kidx_t  cnt_reg, cnt_next;
    kidx_t  idx_reg, idx_next;
    logic   dec_reg, dec_next;
    blk_t   blk_reg, blk_next;
    blk_t   out_reg, out_next;
    logic   m_tvalid_reg, m_tvalid_next;

    op_t    op;
    logic   s_xfer, ram_we, ram_re, out_free, is_block;
    kidx_t  ram_raddr;
    word_t  key_rd;
    blk_t   blk_in, round_out;

    assign op       = op_t'(s_tuser);
    assign s_tready = (state_reg == ST_IDLE);
    assign s_xfer   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_reg;
    assign ram_we   = s_xfer && (op == OP_LOAD);

    // unpack block words from the input transfer
    always_comb begin
        for (int i = 0; i < 8; i++) begin
            blk_in[i] = s_tdata[38 + 32*i +: 32];
        end
    end

    always_comb begin
        unique case (op) inside
            OP_ENC, OP_DEC: is_block = 1'b1;
            default:        is_block = 1'b0;
        endcase
    end

    shc2_ram #(
        .WIDTH (32),
        .DEPTH (KEY_SLOTS)
    ) u_key_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (s_tdata[KEY_AW-1:0]),
        .wdata (s_tdata[37:6]),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (key_rd)
    );

    shc2_round u_round (
        .state_in  (blk_reg),
        .key       (key_rd),
        .decrypt   (dec_reg),
        .state_out (round_out)
    );

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // round datapath registers
    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        idx_reg <= idx_next;
        dec_reg <= dec_next;
        blk_reg <= blk_next;
        out_reg <= out_next;
    end

    // next state, key read scheduling and result capture
    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        idx_next      = idx_reg;
        dec_next      = dec_reg;
        blk_next      = blk_reg;
        out_next      = out_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        ram_re        = 1'b0;
        ram_raddr     = dec_reg ? (idx_reg - kidx_t'(1)) : (idx_reg + kidx_t'(1));
        unique case (state_reg)
            ST_IDLE: begin
                ram_raddr = (op == OP_DEC) ? LAST_IDX : '0;
                if (s_xfer && is_block) begin
                    ram_re     = 1'b1;
                    state_next = ST_RUN;
                    cnt_next   = LAST_IDX;
                    idx_next   = ram_raddr;
                    dec_next   = (op == OP_DEC);
                    blk_next   = blk_in;
                end
            end
            ST_RUN: begin
                if (cnt_reg != '0) begin
                    // key for the next round is fetched as this one completes
                    ram_re   = 1'b1;
                    idx_next = ram_raddr;
                    cnt_next = cnt_reg - kidx_t'(1);
                    blk_next = round_out;
                end else if (out_free) begin
                    // last round goes straight into the result register
                    out_next      = round_out;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `SHC2_ASSERT_NEXT(a_block_starts, s_xfer && is_block, state_reg == ST_RUN,
        "block transfer did not start the round sequence")
    `SHC2_ASSERT_NOW(a_load_idle, ram_we, state_reg == ST_IDLE,
        "key store written while rounds in progress")
    `SHC2_ASSERT_NEXT(a_cnt_step, state_reg == ST_RUN && cnt_reg != '0,
        cnt_reg == $past(cnt_reg) - kidx_t'(1), "round counter skipped")
    `SHC2_ASSERT_NOW(a_result_src, $rose(m_tvalid_reg),
        $past(state_reg == ST_RUN && cnt_reg == '0), "result raised before last round")

endmodule
`default_nettype wire

### src/shc2_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module shc2_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // read port, data holds while re is low
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

### src/shc2_round.sv
// One SHACAL-2 round, forward or inverse, as combinational logic.
`default_nettype none
module shc2_round (
    input  wire shc2_pkg::blk_t  state_in,
    input  wire shc2_pkg::word_t key,
    input  wire logic            decrypt,
    output shc2_pkg::blk_t       state_out
);
    import shc2_pkg::*;

    word_t f_t1, f_t2;
    word_t r_t1, r_t2, r_d, r_h;

    // forward round
    always_comb begin
        f_t1 = state_in[7] + big_s1(state_in[4])
             + ch32(state_in[4], state_in[5], state_in[6]) + key;
        f_t2 = big_s0(state_in[0]) + maj32(state_in[0], state_in[1], state_in[2]);
    end

    // inverse round: recover d and h from the shifted words
    always_comb begin
        r_t2 = big_s0(state_in[1]) + maj32(state_in[1], state_in[2], state_in[3]);
        r_t1 = state_in[0] - r_t2;
        r_d  = state_in[4] - r_t1;
        r_h  = r_t1 - big_s1(state_in[5])
             - ch32(state_in[5], state_in[6], state_in[7]) - key;
    end

    always_comb begin
        if (decrypt) begin
            state_out[0] = state_in[1];
            state_out[1] = state_in[2];
            state_out[2] = state_in[3];
            state_out[3] = r_d;
            state_out[4] = state_in[5];
            state_out[5] = state_in[6];
            state_out[6] = state_in[7];
            state_out[7] = r_h;
        end else begin
            state_out[0] = f_t1 + f_t2;
            state_out[1] = state_in[0];
            state_out[2] = state_in[1];
            state_out[3] = state_in[2];
            state_out[4] = state_in[3] + f_t1;
            state_out[5] = state_in[4];
            state_out[6] = state_in[5];
            state_out[7] = state_in[6];
        end
    end

endmodule
`default_nettype wire
